### src/mrv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrv_pkg: shared types and constants for the RV32 ADDI/ADD/SW core
// Opcodes, function codes, status codes and the structs passed between
// the register file, the execute unit and the top level.
// ----------------------------------------------------------------------------
package mrv_pkg;

    // Opcodes and function fields of the supported instructions
    localparam logic [6:0]  OP_ADDI     = 7'h13;
    localparam logic [6:0]  OP_ADD      = 7'h33;
    localparam logic [6:0]  OP_SW       = 7'h23;
    localparam logic [2:0]  F3_ADD      = 3'd0;
    localparam logic [2:0]  F3_SW       = 3'd2;
    localparam logic [6:0]  F7_ADD      = 7'd0;

    // Special words and address map
    localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;
    localparam logic [31:0] WORD_EMPTY  = 32'h0000_0000;
    localparam logic [31:0] FB_BASE     = 32'h2000_0000;

    // Register indexes with fixed roles
    localparam logic [4:0]  REG_ZERO    = 5'd0;
    localparam logic [4:0]  REG_SP      = 5'd2;
    localparam logic [4:0]  REG_A0      = 5'd10;

    // Status codes
    localparam logic [2:0]  ST_RUN      = 3'd0;
    localparam logic [2:0]  ST_GOOD     = 3'd1;
    localparam logic [2:0]  ST_BAD      = 3'd2;
    localparam logic [2:0]  ST_EMPTY    = 3'd3;
    localparam logic [2:0]  ST_BADPC    = 3'd4;

    // Register file write request
    typedef struct packed {
        logic        en;
        logic [4:0]  addr;
        logic [31:0] data;
    } t_rf_wr;

    // One result item
    typedef struct packed {
        logic [31:0] fetch_address;
        logic        write_enable;
        logic        write_to_framebuffer;
        logic [23:0] write_address;
        logic [31:0] write_data;
        logic [2:0]  status;
        logic [31:0] exit_value;
    } t_result;

    // Everything the execute unit decides for one instruction
    typedef struct packed {
        logic [31:0] pc_next;
        logic        halted_next;
        logic [2:0]  reason_next;
        t_rf_wr      rf_wr;
        t_result     res;
    } t_exec;

endpackage

### src/minimal_rv32_addi_add_sw_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minimal_rv32_addi_add_sw_core: RV32 subset core running ADDI, ADD and SW
// One instruction word in per transfer, one result item out per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall carry i_instruction, the word fetched
//   from the last reported o_fetch_address. Output channel: o_valid /
//   i_stall carry the next fetch address, the store request (memory byte
//   address or framebuffer word index), the status and the exit value.
//   The register file is read at the input transfer, and the execute unit
//   fills the result register when the instruction advances. Throughput is
//   one instruction per cycle while i_stall is low; a register write from
//   the execute stage is forwarded to the operands read in the same cycle.
//   Reset clears the register file (sp holds memory size minus 4), the
//   halted flag and the pc to zero, with no sweep. i_cfg_wr_en loads the
//   24-bit start address into the pc; write it only when idle.
//   While i_stall is high the result holds; one more item is taken into
//   the input stage and then o_stall rises. Once halted, every later
//   instruction is ignored and the halt status repeats.
// ----------------------------------------------------------------------------
module minimal_rv32_addi_add_sw_core #(
    parameter int MEMORY_BYTES      = 16777216,
    parameter int FRAMEBUFFER_BYTES = 262144
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [23:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_instruction,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_fetch_address,
    output logic        o_write_enable,
    output logic        o_write_to_framebuffer,
    output logic [23:0] o_write_address,
    output logic [31:0] o_write_data,
    output logic [2:0]  o_status,
    output logic [31:0] o_exit_value
);

    import mrv_pkg::*;

    logic        r_s1_valid;
    logic [31:0] r_instr;
    logic        r_out_valid;
    t_result     r_out;
    logic [31:0] r_pc;
    logic        r_halted;
    logic [2:0]  r_reason;
    logic        n_s1_valid;
    logic        n_out_valid;
    logic        out_free;
    logic        s1_adv;
    logic        in_xfer;
    logic [31:0] rs1_data;
    logic [31:0] rs2_data;
    logic [31:0] a0;
    t_exec       ex;
    t_rf_wr      rf_wr;

    // Handshake control
    assign out_free = !r_out_valid || !i_stall;
    assign s1_adv   = r_s1_valid && out_free;
    assign o_stall  = r_s1_valid && !out_free;
    assign in_xfer  = i_valid && !o_stall;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_xfer) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s1_adv) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture the instruction on an input transfer
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_instr <= i_instruction;
        end
    end

    // Write the register file only when the instruction advances
    always_comb begin
        rf_wr    = ex.rf_wr;
        rf_wr.en = ex.rf_wr.en && s1_adv;
    end

    mrv_regfile #(
        .MEMORY_BYTES (MEMORY_BYTES)
    ) u_regfile (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (in_xfer),
        .i_rs1      (i_instruction[19:15]),
        .i_rs2      (i_instruction[24:20]),
        .i_wr       (rf_wr),
        .o_rs1_data (rs1_data),
        .o_rs2_data (rs2_data),
        .o_a0       (a0)
    );

    mrv_exec #(
        .MEMORY_BYTES      (MEMORY_BYTES),
        .FRAMEBUFFER_BYTES (FRAMEBUFFER_BYTES)
    ) u_exec (
        .i_instr    (r_instr),
        .i_rs1_data (rs1_data),
        .i_rs2_data (rs2_data),
        .i_a0       (a0),
        .i_pc       (r_pc),
        .i_halted   (r_halted),
        .i_reason   (r_reason),
        .o_exec     (ex)
    );

    // Architectural state: pc, halt flag and reason
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= '0;
            r_halted <= 1'b0;
            r_reason <= ST_RUN;
        end else if (i_cfg_wr_en) begin
            r_pc     <= {8'd0, i_cfg_wr_data};
        end else if (s1_adv) begin
            r_pc     <= ex.pc_next;
            r_halted <= ex.halted_next;
            r_reason <= ex.reason_next;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= ex.res;
        end
    end

    assign o_valid                = r_out_valid;
    assign o_fetch_address        = r_out.fetch_address;
    assign o_write_enable         = r_out.write_enable;
    assign o_write_to_framebuffer = r_out.write_to_framebuffer;
    assign o_write_address        = r_out.write_address;
    assign o_write_data           = r_out.write_data;
    assign o_status               = r_out.status;
    assign o_exit_value           = r_out.exit_value;

endmodule

### src/mrv_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrv_ram: generic RAM, one write port and two registered read ports
// Read data is captured on a read enable and holds otherwise. A read of an
// address written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module mrv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_a,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read ports
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

### src/mrv_regfile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrv_regfile: 32 x 32 register file with reset values and write bypass
// Operands are read when an instruction is taken in and resolved in the
// next cycle: x0 reads zero, an entry never written reads its reset value,
// and a write landing in the read cycle is forwarded. Keeps a copy of a0.
// ----------------------------------------------------------------------------
module mrv_regfile #(
    parameter int MEMORY_BYTES = 16777216
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [4:0]         i_rs1,
    input  logic [4:0]         i_rs2,
    input  mrv_pkg::t_rf_wr    i_wr,
    output logic [31:0]        o_rs1_data,
    output logic [31:0]        o_rs2_data,
    output logic [31:0]        o_a0
);

    import mrv_pkg::*;

    localparam logic [31:0] SP_RESET = 32'(MEMORY_BYTES - 4);

    logic [31:0] r_vld;
    logic [31:0] r_a0;
    logic [4:0]  r_rs1;
    logic [4:0]  r_rs2;
    logic        r_fwd1;
    logic        r_fwd2;
    logic [31:0] r_fwd_data;
    logic [31:0] ram_a;
    logic [31:0] ram_b;
    logic [31:0] raw1;
    logic [31:0] raw2;

    mrv_ram #(
        .WIDTH (32),
        .DEPTH (32)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (i_wr.en),
        .i_wr_addr   (i_wr.addr),
        .i_wr_data   (i_wr.data),
        .i_rd_en     (i_rd_en),
        .i_rd_addr_a (i_rs1),
        .i_rd_addr_b (i_rs2),
        .o_rd_data_a (ram_a),
        .o_rd_data_b (ram_b)
    );

    // Mark written entries, track a0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_a0  <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
            if (i_wr.addr == REG_A0) begin
                r_a0 <= i_wr.data;
            end
        end
    end

    // Hold read indexes and catch a write to the same entry in the read cycle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rs1      <= i_rs1;
            r_rs2      <= i_rs2;
            r_fwd1     <= i_wr.en && (i_wr.addr == i_rs1);
            r_fwd2     <= i_wr.en && (i_wr.addr == i_rs2);
            r_fwd_data <= i_wr.data;
        end
    end

    assign raw1 = r_fwd1 ? r_fwd_data : ram_a;
    assign raw2 = r_fwd2 ? r_fwd_data : ram_b;

    // Resolve operands: zero register, reset value, stored value
    always_comb begin
        if (r_rs1 == REG_ZERO) begin
            o_rs1_data = '0;
        end else if (r_vld[r_rs1]) begin
            o_rs1_data = raw1;
        end else begin
            o_rs1_data = (r_rs1 == REG_SP) ? SP_RESET : '0;
        end
        if (r_rs2 == REG_ZERO) begin
            o_rs2_data = '0;
        end else if (r_vld[r_rs2]) begin
            o_rs2_data = raw2;
        end else begin
            o_rs2_data = (r_rs2 == REG_SP) ? SP_RESET : '0;
        end
    end

    assign o_a0 = r_a0;

endmodule

### src/mrv_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrv_exec: execute unit for one instruction
// Checks the pc, traps on ebreak and the empty word, executes ADDI, ADD and
// SW, routes stores to the framebuffer window or main memory, and builds
// the next pc, halt state, register write and result item.
// ----------------------------------------------------------------------------
module mrv_exec #(
    parameter int MEMORY_BYTES      = 16777216,
    parameter int FRAMEBUFFER_BYTES = 262144
) (
    input  logic [31:0]     i_instr,
    input  logic [31:0]     i_rs1_data,
    input  logic [31:0]     i_rs2_data,
    input  logic [31:0]     i_a0,
    input  logic [31:0]     i_pc,
    input  logic            i_halted,
    input  logic [2:0]      i_reason,
    output mrv_pkg::t_exec  o_exec
);

    import mrv_pkg::*;

    localparam logic [31:0] MEM_LIM  = 32'(MEMORY_BYTES - 3);
    localparam logic [31:0] FB_BYTES = 32'(FRAMEBUFFER_BYTES);

    logic [6:0]  opcode;
    logic [4:0]  rd;
    logic [2:0]  funct3;
    logic [6:0]  funct7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic        is_addi;
    logic        is_add;
    logic        is_sw;
    logic        bad_pc;
    logic [31:0] st_addr;
    logic [31:0] fb_off;
    logic        in_fb;
    logic        in_mem;
    logic [2:0]  status;

    // Decode fields and immediates
    assign opcode  = i_instr[6:0];
    assign rd      = i_instr[11:7];
    assign funct3  = i_instr[14:12];
    assign funct7  = i_instr[31:25];
    assign imm_i   = {{20{i_instr[31]}}, i_instr[31:20]};
    assign imm_s   = {{20{i_instr[31]}}, i_instr[31:25], i_instr[11:7]};
    assign is_addi = (opcode == OP_ADDI) && (funct3 == F3_ADD);
    assign is_add  = (opcode == OP_ADD) && (funct3 == F3_ADD) && (funct7 == F7_ADD);
    assign is_sw   = (opcode == OP_SW) && (funct3 == F3_SW);
    assign bad_pc  = (i_pc >= MEM_LIM) || (i_pc[1:0] != 2'b00);

    // Store address and window checks
    assign st_addr = i_rs1_data + imm_s;
    assign fb_off  = st_addr - FB_BASE;
    assign in_fb   = (st_addr >= FB_BASE) && (fb_off < FB_BYTES);
    assign in_mem  = st_addr < MEM_LIM;

    // Next state and result
    always_comb begin
        o_exec             = '0;
        o_exec.pc_next     = i_pc;
        o_exec.halted_next = i_halted;
        o_exec.reason_next = i_reason;

        if (!i_halted) begin
            if (bad_pc) begin
                o_exec.halted_next = 1'b1;
                o_exec.reason_next = ST_BADPC;
            end else if (i_instr == WORD_EBREAK) begin
                o_exec.halted_next = 1'b1;
                o_exec.reason_next = (i_a0 == '0) ? ST_GOOD : ST_BAD;
            end else if (i_instr == WORD_EMPTY) begin
                o_exec.halted_next = 1'b1;
                o_exec.reason_next = ST_EMPTY;
            end else begin
                o_exec.pc_next = i_pc + 32'd4;
                if (is_addi) begin
                    o_exec.rf_wr.en   = (rd != REG_ZERO);
                    o_exec.rf_wr.addr = rd;
                    o_exec.rf_wr.data = i_rs1_data + imm_i;
                end else if (is_add) begin
                    o_exec.rf_wr.en   = (rd != REG_ZERO);
                    o_exec.rf_wr.addr = rd;
                    o_exec.rf_wr.data = i_rs1_data + i_rs2_data;
                end else if (is_sw) begin
                    if (in_fb) begin
                        o_exec.res.write_enable         = 1'b1;
                        o_exec.res.write_to_framebuffer = 1'b1;
                        o_exec.res.write_address        = fb_off[25:2];
                        o_exec.res.write_data           = i_rs2_data;
                    end else if (in_mem) begin
                        o_exec.res.write_enable  = 1'b1;
                        o_exec.res.write_address = st_addr[23:0];
                        o_exec.res.write_data    = i_rs2_data;
                    end
                end
            end
        end

        // Report pc and status after this step
        status                  = o_exec.halted_next ? o_exec.reason_next : ST_RUN;
        o_exec.res.fetch_address = o_exec.pc_next;
        o_exec.res.status        = status;
        o_exec.res.exit_value    = (status == ST_GOOD || status == ST_BAD) ? i_a0 : '0;
    end

endmodule
